/* hw/rtl/dsp_pkg.sv */
// ---------------------------------------------------------------------------
// dsp_pkg: shared types and constants of the decimal scientific parser
// Character codes, error codes, limits, the parse snapshot and bit-length
// helpers used by the scan stage, the result stage and the top level.
// ---------------------------------------------------------------------------
package dsp_pkg;

  // Longest accepted number text, in characters
  localparam int unsigned MAX_CHARS = 64;
  // Character position counter saturates at MAX_CHARS
  localparam int unsigned POS_W = $clog2(MAX_CHARS + 1);
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_CHARS);

  localparam int unsigned MAG_W  = 63;
  localparam int unsigned EXP_W  = 16;
  localparam int unsigned MBIT_W = 6;
  localparam int unsigned EBIT_W = 5;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_E_LO  = 8'h65;
  localparam logic [7:0] CH_E_UP  = 8'h45;

  // Error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_MALFORMED = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd2;

  // Parse state captured on the last character of a text
  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             minus;
    logic [EXP_W-1:0] frac;
    logic [EXP_W-1:0] exp_acc;
    logic             exp_minus;
    logic             exp_ovf;
    logic [1:0]       err;
  } snap_t;

  // Bit length of a magnitude, 0 for zero
  function automatic logic [MBIT_W-1:0] bit_len_mag(input logic [MAG_W-1:0] v);
    logic [MBIT_W-1:0] n;
    n = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (v[i]) n = MBIT_W'(i + 1);
    end
    return n;
  endfunction

  // Bit length of an absolute exponent, 0 for zero
  function automatic logic [EBIT_W-1:0] bit_len_exp(input logic [EXP_W-1:0] v);
    logic [EBIT_W-1:0] n;
    n = '0;
    for (int i = 0; i < EXP_W; i++) begin
      if (v[i]) n = EBIT_W'(i + 1);
    end
    return n;
  endfunction

endpackage

/* hw/rtl/decimal_scientific_parser.sv */
// ---------------------------------------------------------------------------
// decimal_scientific_parser: decimal text to magnitude and power of ten
// Characters of a number text such as -1.25e-3 enter one per item on the
// in_ channel (in_char_code, in_last_char). The character flagged last
// produces one result item on the out_ channel; other characters produce none.
// Result: sign, digit magnitude, exponent = written exponent minus fraction
// digits, bit lengths of magnitude and |exponent|, and an error code
// (0 ok, 1 malformed, 2 overflow saturated or clamped).
// Throughput: one character per cycle while in_ready is high. A result item
// reaches out_ through the snapshot register, which captures the text when its
// last character is accepted, and then the output register, which takes it
// from the snapshot once the output register is free or being emptied.
// A stalled receiver holds the output register, and one more finished text
// can wait in the snapshot register.
// in_ready drops only when both are full and the output is not being taken.
// Reset (rst_n low, synchronous) clears the parse state and both valid flags.
// ---------------------------------------------------------------------------
module decimal_scientific_parser (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_char_code,
  input  logic                                in_last_char,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_is_negative,
  output logic [dsp_pkg::MAG_W-1:0]           out_magnitude,
  output logic signed [dsp_pkg::EXP_W-1:0]    out_scale_exponent,
  output logic [dsp_pkg::MBIT_W-1:0]          out_magnitude_bits,
  output logic [dsp_pkg::EBIT_W-1:0]          out_exponent_bits,
  output logic [1:0]                          out_parse_error
);

  logic           snap_valid;
  logic           snap_take;
  dsp_pkg::snap_t snap;

  logic                             res_neg;
  logic [dsp_pkg::MAG_W-1:0]        res_mag;
  logic signed [dsp_pkg::EXP_W-1:0] res_exp;
  logic [dsp_pkg::MBIT_W-1:0]       res_mbits;
  logic [dsp_pkg::EBIT_W-1:0]       res_ebits;
  logic [1:0]                       res_err;

  logic out_valid_r, out_valid_nxt;
  logic                             neg_r;
  logic [dsp_pkg::MAG_W-1:0]        mag_r;
  logic signed [dsp_pkg::EXP_W-1:0] exp_r;
  logic [dsp_pkg::MBIT_W-1:0]       mbits_r;
  logic [dsp_pkg::EBIT_W-1:0]       ebits_r;
  logic [1:0]                       err_r;

  // Snapshot moves on when the output register is free or being emptied
  assign snap_take = snap_valid && (!out_valid_r || out_ready);

  dsp_scan u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .in_last_char (in_last_char),
    .snap_take    (snap_take),
    .snap_valid   (snap_valid),
    .snap         (snap)
  );

  dsp_result u_result (
    .snap           (snap),
    .is_negative    (res_neg),
    .magnitude      (res_mag),
    .scale_exponent (res_exp),
    .magnitude_bits (res_mbits),
    .exponent_bits  (res_ebits),
    .parse_error    (res_err)
  );

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (snap_take)      out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take) begin
      neg_r   <= res_neg;
      mag_r   <= res_mag;
      exp_r   <= res_exp;
      mbits_r <= res_mbits;
      ebits_r <= res_ebits;
      err_r   <= res_err;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_is_negative    = neg_r;
  assign out_magnitude      = mag_r;
  assign out_scale_exponent = exp_r;
  assign out_magnitude_bits = mbits_r;
  assign out_exponent_bits  = ebits_r;
  assign out_parse_error    = err_r;

endmodule

/* hw/rtl/dsp_scan.sv */
// ---------------------------------------------------------------------------
// dsp_scan: per-character parse stage
// Holds the running parse state, updates it for each accepted character and
// captures a snapshot of the final state when the last character arrives.
// ---------------------------------------------------------------------------
module dsp_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_char_code,
  input  logic                in_last_char,
  input  logic                snap_take,
  output logic                snap_valid,
  output dsp_pkg::snap_t      snap
);

  // Running parse state
  logic [dsp_pkg::MAG_W-1:0] acc_r, acc_nxt;
  logic                      minus_r, minus_nxt;
  logic [dsp_pkg::EXP_W-1:0] frac_r, frac_nxt;
  logic                      point_r, point_nxt;
  logic                      in_exp_r, in_exp_nxt;
  logic [dsp_pkg::EXP_W-1:0] exp_acc_r, exp_acc_nxt;
  logic                      exp_minus_r, exp_minus_nxt;
  logic                      exp_ovf_r, exp_ovf_nxt;
  logic [1:0]                err_r, err_nxt;
  logic [dsp_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic                      mant_seen_r, mant_seen_nxt;
  logic                      exp_seen_r, exp_seen_nxt;
  logic                      exp_sign_r, exp_sign_nxt;

  logic           snap_valid_r, snap_valid_nxt;
  dsp_pkg::snap_t snap_r, snap_nxt;

  logic        accept;
  logic        is_digit;
  logic [3:0]  digit;
  logic [66:0] mant_prod;
  logic [19:0] exp_prod;
  logic        final_bad;
  logic [1:0]  final_err;

  assign in_ready   = !snap_valid_r || snap_take;
  assign accept     = in_valid && in_ready;
  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

  // Character class and multiply-by-ten accumulates
  assign is_digit  = (in_char_code >= dsp_pkg::CH_ZERO) && (in_char_code <= dsp_pkg::CH_NINE);
  assign digit     = 4'(in_char_code - dsp_pkg::CH_ZERO);
  assign mant_prod = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + {63'b0, digit};
  assign exp_prod  = ({4'b0, exp_acc_r} << 3) + ({4'b0, exp_acc_r} << 1) + {16'b0, digit};

  // Next parse state for the current character
  always_comb begin
    acc_nxt       = acc_r;
    minus_nxt     = minus_r;
    frac_nxt      = frac_r;
    point_nxt     = point_r;
    in_exp_nxt    = in_exp_r;
    exp_acc_nxt   = exp_acc_r;
    exp_minus_nxt = exp_minus_r;
    exp_ovf_nxt   = exp_ovf_r;
    err_nxt       = err_r;
    pos_nxt       = pos_r;
    mant_seen_nxt = mant_seen_r;
    exp_seen_nxt  = exp_seen_r;
    exp_sign_nxt  = exp_sign_r;

    // too many characters
    if (pos_r >= dsp_pkg::POS_LIMIT) err_nxt = dsp_pkg::ERR_MALFORMED;
    if (pos_r <  dsp_pkg::POS_LIMIT) pos_nxt = pos_r + 1'b1;

    if (is_digit) begin
      if (in_exp_r) begin
        exp_seen_nxt = 1'b1;
        if (exp_prod[19:16] != 4'b0) begin
          exp_acc_nxt = '1;
          exp_ovf_nxt = 1'b1;
        end else begin
          exp_acc_nxt = exp_prod[15:0];
        end
      end else begin
        mant_seen_nxt = 1'b1;
        if (mant_prod[66:63] != 4'b0) begin
          acc_nxt = '1;
          if (err_nxt == dsp_pkg::ERR_NONE) err_nxt = dsp_pkg::ERR_OVERFLOW;
        end else begin
          acc_nxt = mant_prod[62:0];
        end
        if (point_r && (frac_r != '1)) frac_nxt = frac_r + 1'b1;
      end
    end else if ((in_char_code == dsp_pkg::CH_PLUS) || (in_char_code == dsp_pkg::CH_MINUS)) begin
      if (in_exp_r) begin
        if (exp_seen_r || exp_sign_r) begin
          err_nxt = dsp_pkg::ERR_MALFORMED;
        end else begin
          exp_sign_nxt  = 1'b1;
          exp_minus_nxt = (in_char_code == dsp_pkg::CH_MINUS);
        end
      end else if (pos_r == '0) begin
        minus_nxt = (in_char_code == dsp_pkg::CH_MINUS);
      end else begin
        err_nxt = dsp_pkg::ERR_MALFORMED;
      end
    end else if (in_char_code == dsp_pkg::CH_POINT) begin
      if (in_exp_r || point_r) err_nxt = dsp_pkg::ERR_MALFORMED;
      else                     point_nxt = 1'b1;
    end else if ((in_char_code == dsp_pkg::CH_E_LO) || (in_char_code == dsp_pkg::CH_E_UP)) begin
      if (in_exp_r || !mant_seen_r) err_nxt = dsp_pkg::ERR_MALFORMED;
      else                          in_exp_nxt = 1'b1;
    end else begin
      err_nxt = dsp_pkg::ERR_MALFORMED;
    end
  end

  // End-of-text checks on the updated state
  assign final_bad = !mant_seen_nxt || (in_exp_nxt && !exp_seen_nxt);
  assign final_err = final_bad ? dsp_pkg::ERR_MALFORMED : err_nxt;

  always_comb begin
    snap_nxt.mag       = acc_nxt;
    snap_nxt.minus     = minus_nxt;
    snap_nxt.frac      = frac_nxt;
    snap_nxt.exp_acc   = exp_acc_nxt;
    snap_nxt.exp_minus = exp_minus_nxt;
    snap_nxt.exp_ovf   = exp_ovf_nxt;
    snap_nxt.err       = final_err;
  end

  // Snapshot handoff
  always_comb begin
    snap_valid_nxt = snap_valid_r;
    if (accept && in_last_char) snap_valid_nxt = 1'b1;
    else if (snap_take)         snap_valid_nxt = 1'b0;
  end

  // Parse state: updated per item, cleared after the last character
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_last_char)) begin
      acc_r       <= '0;
      minus_r     <= 1'b0;
      frac_r      <= '0;
      point_r     <= 1'b0;
      in_exp_r    <= 1'b0;
      exp_acc_r   <= '0;
      exp_minus_r <= 1'b0;
      exp_ovf_r   <= 1'b0;
      err_r       <= dsp_pkg::ERR_NONE;
      pos_r       <= '0;
      mant_seen_r <= 1'b0;
      exp_seen_r  <= 1'b0;
      exp_sign_r  <= 1'b0;
    end else if (accept) begin
      acc_r       <= acc_nxt;
      minus_r     <= minus_nxt;
      frac_r      <= frac_nxt;
      point_r     <= point_nxt;
      in_exp_r    <= in_exp_nxt;
      exp_acc_r   <= exp_acc_nxt;
      exp_minus_r <= exp_minus_nxt;
      exp_ovf_r   <= exp_ovf_nxt;
      err_r       <= err_nxt;
      pos_r       <= pos_nxt;
      mant_seen_r <= mant_seen_nxt;
      exp_seen_r  <= exp_seen_nxt;
      exp_sign_r  <= exp_sign_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
    end else begin
      snap_valid_r <= snap_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_last_char) snap_r <= snap_nxt;
  end

endmodule

/* hw/rtl/dsp_result.sv */
// ---------------------------------------------------------------------------
// dsp_result: result formatting
// Turns a parse snapshot into sign, magnitude, clamped exponent, bit lengths
// and the error code.
// ---------------------------------------------------------------------------
module dsp_result (
  input  dsp_pkg::snap_t              snap,
  output logic                        is_negative,
  output logic [dsp_pkg::MAG_W-1:0]   magnitude,
  output logic signed [dsp_pkg::EXP_W-1:0] scale_exponent,
  output logic [dsp_pkg::MBIT_W-1:0]  magnitude_bits,
  output logic [dsp_pkg::EBIT_W-1:0]  exponent_bits,
  output logic [1:0]                  parse_error
);

  logic                      bad;
  logic                      mag_zero;
  logic signed [17:0]        exp_signed;
  logic signed [17:0]        e_raw;
  logic                      clamp_hi, clamp_lo;
  logic signed [dsp_pkg::EXP_W-1:0] e_cl;
  logic [dsp_pkg::EXP_W-1:0] abs_e;
  logic                      ovf;

  assign bad      = (snap.err == dsp_pkg::ERR_MALFORMED);
  assign mag_zero = (snap.mag == '0);

  // written exponent minus fraction digits, then clamp
  assign exp_signed = snap.exp_minus ? -$signed({2'b0, snap.exp_acc})
                                     :  $signed({2'b0, snap.exp_acc});
  assign e_raw    = exp_signed - $signed({2'b0, snap.frac});
  assign clamp_hi = (e_raw > 18'sd32767);
  assign clamp_lo = (e_raw < -18'sd32768);

  always_comb begin
    priority if (mag_zero) e_cl = '0;
    else if (clamp_hi)     e_cl = 16'sh7FFF;
    else if (clamp_lo)     e_cl = 16'sh8000;
    else                   e_cl = e_raw[15:0];
  end

  assign abs_e = e_cl[15] ? 16'(-e_cl) : e_cl;
  assign ovf   = !mag_zero && (snap.exp_ovf || clamp_hi || clamp_lo);

  // malformed text forces all-zero result fields and the malformed error code
  always_comb begin
    if (bad) begin
      is_negative    = 1'b0;
      magnitude      = '0;
      scale_exponent = '0;
      magnitude_bits = '0;
      exponent_bits  = '0;
      parse_error    = dsp_pkg::ERR_MALFORMED;
    end else begin
      is_negative    = snap.minus && !mag_zero;
      magnitude      = snap.mag;
      scale_exponent = e_cl;
      magnitude_bits = dsp_pkg::bit_len_mag(snap.mag);
      exponent_bits  = dsp_pkg::bit_len_exp(abs_e);
      parse_error    = (ovf && (snap.err == dsp_pkg::ERR_NONE)) ? dsp_pkg::ERR_OVERFLOW
                                                                 : snap.err;
    end
  end

endmodule
